// ===== rtl/feel_pkg.sv =====
// ----------------------------------------------------------------------------
// feel_pkg: shared constants for the flash EEPROM emulation log
// Holds page states, record markers, action and status codes, the table of
// kept keys and the default sizes.
// ----------------------------------------------------------------------------
package feel_pkg;

  // Default sizes.
  localparam int PAGE_BYTES_DEF    = 1024;
  localparam int NUM_KEPT_KEYS_DEF = 5;
  localparam int KEY_TABLE_SIZE    = 16;

  // Width of byte offsets; holds a page offset plus the longest record.
  localparam int OW = 18;

  // Page header states and record markers.
  localparam logic [15:0] ST_RECEIVE  = 16'hEEEE;
  localparam logic [15:0] ST_VALID    = 16'hAAAA;
  localparam logic [15:0] COMMIT_WORD = 16'hA55A;
  localparam logic [15:0] ERASED_HW   = 16'hFFFF;
  localparam logic [15:0] SEQ_HALF    = 16'h8000;
  localparam logic [15:0] HDR_BYTES   = 16'd8;

  // Actions.
  localparam logic [1:0] ACT_INIT  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_RAW   = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FAIL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  // Kept-key table in move order; only the first NUM_KEPT_KEYS entries survive a page move.
  localparam logic [15:0] KEPT_KEYS [KEY_TABLE_SIZE] = '{
    16'h0100, 16'h0010, 16'h0011, 16'h0012, 16'h0013, 16'h0014, 16'h0015, 16'h0016,
    16'h0017, 16'h0018, 16'h0019, 16'h001A, 16'h001B, 16'h001C, 16'h001D, 16'h001E
  };

endpackage

// ===== rtl/flash_eeprom_emulation_log.sv =====
// ----------------------------------------------------------------------------
// flash_eeprom_emulation_log: two-page EEPROM emulation over a flash store
// Keeps a record log in one of two flash pages and moves the kept keys to the
// other page when the active one fills.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole store to the erased value, one
// halfword per cycle, and takes no item meanwhile. Every item then runs to
// completion in a small sequencer around one store memory (read data
// registered) before the next one is taken. A program reads a halfword, then
// writes it ANDed with the value; an erase writes the erased value over a
// page; a log walk reads the key, length and commit word of each record. A
// write stages a halfword and appends the record on the last one; a read
// walks the log and fetches one halfword; init reads both page headers, then
// walks the active page (or erases and formats page 0); a page move erases
// the other page, walks once per kept key, copies records and erases the old page.
module flash_eeprom_emulation_log
  import feel_pkg::*;
#(
  parameter int PAGE_BYTES    = PAGE_BYTES_DEF,
  parameter int NUM_KEPT_KEYS = NUM_KEPT_KEYS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] key,
  input  logic [15:0] length,
  input  logic [15:0] data,
  input  logic        last,
  input  logic [9:0]  index,
  input  logic [15:0] max_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [9:0]  copy_length,
  output logic [15:0] read_data,
  output logic        active_page,
  output logic [10:0] write_pointer
);

  localparam int PAGE_HW  = PAGE_BYTES / 2;
  localparam int STORE_HW = PAGE_BYTES;
  localparam int AW       = $clog2(STORE_HW);
  localparam int SBW      = $clog2(PAGE_HW);
  localparam int RW       = (AW + 1 > 10) ? AW + 1 : 10;
  localparam int KEY_LIM  = (NUM_KEPT_KEYS < KEY_TABLE_SIZE) ? NUM_KEPT_KEYS : KEY_TABLE_SIZE;
  localparam logic [OW-1:0] PG_LIMIT = OW'(PAGE_BYTES);
  localparam logic [15:0]   MAX_REC  = 16'(PAGE_BYTES - 14);

  typedef enum logic [5:0] {
    S_IDLE, S_DISP, S_DONE, S_OKD,
    S_I1, S_I2, S_I3, S_I4, S_I5, S_I6, S_IF1, S_IF2, S_IF3, S_ISCAN, S_IS2,
    S_W0, S_W1, S_AD, S_RD1, S_RD2, S_RAW,
    S_M1, S_M2, S_M3, S_MK, S_MF, S_MN, S_MV, S_ME, S_MD,
    S_E_KEY, S_E_LEN, S_E_DAT, S_E_DV, S_E_END,
    S_WK_A, S_WK_B, S_WK_C, S_WK_D,
    S_P_RD, S_P_WR, S_ER
  } state_t;

  state_t state;

  // Store memory and staging buffer.
  logic [15:0] store [STORE_HW];
  logic [15:0] sbuf [PAGE_HW];
  logic [15:0] st_q, sb_q;
  logic [AW-1:0] st_raddr, st_waddr;
  logic [15:0] st_wdata;
  logic st_we, sb_we;

  // Latched item.
  logic [1:0]  a_act;
  logic [15:0] a_key, a_len, a_data, a_maxl;
  logic        a_last;
  logic [9:0]  a_index;

  // Block state.
  logic          initialized;
  logic [OW-1:0] wp;
  logic [SBW:0]  sc;

  // Walk unit.
  logic          w_pg, w_any, w_torn, w_found;
  logic [15:0]   w_want, w_k, w_l, w_dlen;
  logic [OW-1:0] w_p, w_doff;
  state_t        w_ret;

  // Program and erase units.
  logic [AW-1:0] p_addr;
  logic [15:0]   p_val;
  state_t        p_ret;
  logic [AW:0]   er_addr, er_end;
  state_t        er_ret;

  // Record emitter.
  logic          e_pg, e_stg;
  logic [15:0]   e_key, e_len;
  logic [OW-1:0] e_doff, w;
  logic [SBW:0]  e_j;
  state_t        e_ret;

  // Init and move bookkeeping.
  logic [15:0] s0, q0, s1, q1;
  logic [4:0]  ki;
  logic [RW-1:0] r_addr;
  logic [15:0] rcopy;

  function automatic logic [AW-1:0] hwa(input logic pg, input logic [OW-1:0] off);
    logic [OW-1:0] h;
    h = (off >> 1) + (pg ? OW'(PAGE_HW) : OW'(0));
    return h[AW-1:0];
  endfunction

  function automatic logic [OW-1:0] even_len(input logic [15:0] l);
    logic [OW-1:0] t;
    t = OW'(l) + OW'(1);
    t[0] = 1'b0;
    return t;
  endfunction

  function automatic logic seq_newer(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return (a != b) && (d < SEQ_HALF);
  endfunction

  // Derived values used by several states.
  logic [OW-1:0] wk_dl_c, wk_dl, e_dl, a_dl, rd_off;
  logic [15:0]   e_n, rd_copy, e_v;
  logic          v0, v1, pick0;

  assign wk_dl_c = even_len(st_q);
  assign wk_dl   = even_len(w_l);
  assign e_dl    = even_len(e_len);
  assign e_n     = e_dl[16:1];
  assign a_dl    = even_len(a_len);
  assign rd_off  = OW'({a_index, 1'b0});
  assign rd_copy = (w_dlen <= a_maxl) ? w_dlen : a_maxl;
  assign v0      = (s0 == ST_VALID);
  assign v1      = (s1 == ST_VALID);
  assign pick0   = seq_newer(q0, q1);

  // Value to program for one data halfword; an odd final byte pads with 0xFF.
  always_comb begin
    e_v = e_stg ? sb_q : st_q;
    if (e_stg && e_len[0] && (16'(e_j) + 16'd1 == e_n)) begin
      e_v = {8'hFF, e_v[7:0]};
    end
  end

  // Store port control, chosen by the sequencer state.
  always_comb begin
    st_raddr = '0;
    st_we    = 1'b0;
    st_waddr = p_addr;
    st_wdata = st_q & p_val;
    unique case (state)
      S_DISP:  st_raddr = hwa(1'b0, OW'(0));
      S_I1:    st_raddr = hwa(1'b0, OW'(2));
      S_I2:    st_raddr = hwa(1'b1, OW'(0));
      S_I3:    st_raddr = hwa(1'b1, OW'(2));
      S_WK_A:  st_raddr = hwa(w_pg, w_p);
      S_WK_B:  st_raddr = hwa(w_pg, w_p + OW'(2));
      S_WK_C:  st_raddr = hwa(w_pg, w_p + OW'(4) + wk_dl_c);
      S_P_RD:  st_raddr = p_addr;
      S_P_WR:  st_we = 1'b1;
      S_ER: begin
        st_we    = 1'b1;
        st_waddr = er_addr[AW-1:0];
        st_wdata = ERASED_HW;
      end
      S_M2:    st_raddr = hwa(active_page, OW'(2));
      S_E_DAT: st_raddr = hwa(active_page, e_doff + OW'({e_j, 1'b0}));
      S_RD1:   st_raddr = hwa(active_page, w_doff + rd_off);
      default: st_raddr = '0;
    endcase
  end

  assign sb_we = (state == S_W0) && (sc < (SBW + 1)'(PAGE_HW));

  // Memories.
  always_ff @(posedge clk) begin
    if (st_we) begin
      store[st_waddr] <= st_wdata;
    end
    st_q <= store[st_raddr];
    if (sb_we) begin
      sbuf[sc[SBW-1:0]] <= a_data;
    end
    sb_q <= sbuf[e_j[SBW-1:0]];
  end

  assign in_ready      = (state == S_IDLE);
  assign out_valid     = (state == S_DONE);
  assign copy_length   = rcopy[9:0];
  assign write_pointer = wp[10:0];

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_ER;
      er_addr     <= '0;
      er_end      <= (AW + 1)'(STORE_HW);
      er_ret      <= S_IDLE;
      initialized <= 1'b0;
      active_page <= 1'b0;
      wp          <= '0;
      sc          <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            a_act     <= action;
            a_key     <= key;
            a_len     <= length;
            a_data    <= data;
            a_last    <= last;
            a_index   <= index;
            a_maxl    <= max_length;
            status    <= STAT_FAIL;
            rcopy     <= '0;
            read_data <= '0;
            state     <= S_DISP;
          end
        end

        S_DISP: begin
          if (a_act == ACT_INIT) begin
            state <= S_I1;
          end else if (!initialized) begin
            state <= S_DONE;
          end else begin
            unique case (a_act)
              ACT_WRITE: state <= S_W0;
              ACT_READ: begin
                w_pg <= active_page; w_want <= a_key; w_any <= 1'b1;
                w_p <= OW'(HDR_BYTES); w_torn <= 1'b0; w_found <= 1'b0;
                w_ret <= S_RD1; state <= S_WK_A;
              end
              default: begin
                r_addr <= RW'(a_index);
                state  <= S_RAW;
              end
            endcase
          end
        end

        S_DONE: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end

        S_OKD: begin
          status <= STAT_OK;
          state  <= S_DONE;
        end

        // Init: read both page headers, then pick the active page.
        S_I1: begin s0 <= st_q; state <= S_I2; end
        S_I2: begin q0 <= st_q; state <= S_I3; end
        S_I3: begin s1 <= st_q; state <= S_I4; end
        S_I4: begin q1 <= st_q; state <= S_I5; end
        S_I5: begin
          initialized <= 1'b1;
          sc          <= '0;
          if (v0 != v1) begin
            active_page <= v1;
            state       <= S_ISCAN;
          end else if (v0 && v1) begin
            active_page <= ~pick0;
            state       <= S_ISCAN;
          end else if (s0 == ST_RECEIVE && s1 == ST_RECEIVE) begin
            active_page <= ~pick0;
            state       <= S_I6;
          end else begin
            er_addr <= '0;
            er_end  <= (AW + 1)'(PAGE_HW);
            er_ret  <= S_IF1;
            state   <= S_ER;
          end
        end
        S_I6: begin
          p_addr <= hwa(active_page, OW'(0)); p_val <= ST_VALID;
          p_ret  <= S_ISCAN; state <= S_P_RD;
        end
        S_IF1: begin
          p_addr <= hwa(1'b0, OW'(0)); p_val <= ST_VALID;
          p_ret  <= S_IF2; state <= S_P_RD;
        end
        S_IF2: begin
          p_addr <= hwa(1'b0, OW'(2)); p_val <= 16'd1;
          p_ret  <= S_IF3; state <= S_P_RD;
        end
        S_IF3: begin
          active_page <= 1'b0;
          wp          <= OW'(HDR_BYTES);
          state       <= S_OKD;
        end
        S_ISCAN: begin
          w_pg <= active_page; w_want <= '0; w_any <= 1'b0;
          w_p <= OW'(HDR_BYTES); w_torn <= 1'b0; w_found <= 1'b0;
          w_ret <= S_IS2; state <= S_WK_A;
        end
        S_IS2: begin
          wp    <= w_torn ? PG_LIMIT : w_p;
          state <= S_OKD;
        end

        // Write: stage the halfword, then close the record on the last one.
        S_W0: begin
          if (sc < (SBW + 1)'(PAGE_HW)) begin
            sc <= sc + 1'b1;
          end
          if (a_last) begin
            state <= S_W1;
          end else begin
            state <= S_OKD;
          end
        end
        S_W1: begin
          sc <= '0;
          if (a_len > MAX_REC || OW'(sc) < (a_dl >> 1)) begin
            state <= S_DONE;
          end else if (wp + OW'(6) + a_dl > PG_LIMIT) begin
            er_addr <= (AW + 1)'(hwa(~active_page, OW'(0)));
            er_end  <= (AW + 1)'(hwa(~active_page, OW'(0))) + (AW + 1)'(PAGE_HW);
            er_ret  <= S_M1;
            state   <= S_ER;
          end else begin
            w <= wp; e_pg <= active_page; e_key <= a_key; e_len <= a_len;
            e_stg <= 1'b1; e_doff <= '0; e_ret <= S_AD; state <= S_E_KEY;
          end
        end
        S_AD: begin
          wp    <= w;
          state <= S_OKD;
        end

        // Read: if the walk found the latest record, fetch one halfword.
        S_RD1: begin
          if (!w_found) begin
            status <= STAT_NOT_FOUND;
            state  <= S_DONE;
          end else begin
            rcopy <= rd_copy;
            if (rd_off < OW'(rd_copy)) begin
              state <= S_RD2;
            end else begin
              state <= S_OKD;
            end
          end
        end
        S_RD2: begin
          if (rd_off + OW'(1) >= OW'(rcopy)) begin
            read_data <= {8'h00, st_q[7:0]};
          end else begin
            read_data <= st_q;
          end
          state <= S_OKD;
        end

        // Raw program: fold the address into the store, then AND in.
        S_RAW: begin
          if (r_addr >= RW'(STORE_HW)) begin
            r_addr <= r_addr - RW'(STORE_HW);
          end else begin
            p_addr <= r_addr[AW-1:0]; p_val <= a_data;
            p_ret  <= S_OKD; state <= S_P_RD;
          end
        end

        // Page move.
        S_M1: begin
          p_addr <= hwa(~active_page, OW'(0)); p_val <= ST_RECEIVE;
          p_ret  <= S_M2; state <= S_P_RD;
        end
        S_M2: state <= S_M3;
        S_M3: begin
          p_addr <= hwa(~active_page, OW'(2)); p_val <= st_q + 16'd1;
          p_ret  <= S_MK; state <= S_P_RD;
          ki     <= '0;
          w      <= OW'(HDR_BYTES);
        end
        S_MK: begin
          if (ki < 5'(KEY_LIM)) begin
            if (KEPT_KEYS[ki[3:0]] == a_key) begin
              ki <= ki + 1'b1;
            end else begin
              w_pg <= active_page; w_want <= KEPT_KEYS[ki[3:0]]; w_any <= 1'b1;
              w_p <= OW'(HDR_BYTES); w_torn <= 1'b0; w_found <= 1'b0;
              w_ret <= S_MF; state <= S_WK_A;
            end
          end else begin
            state <= S_MN;
          end
        end
        S_MF: begin
          ki <= ki + 1'b1;
          if (!w_found) begin
            state <= S_MK;
          end else if (w + OW'(6) + even_len(w_dlen) > PG_LIMIT) begin
            state <= S_DONE;
          end else begin
            e_pg <= ~active_page; e_key <= KEPT_KEYS[ki[3:0]]; e_len <= w_dlen;
            e_stg <= 1'b0; e_doff <= w_doff; e_ret <= S_MK; state <= S_E_KEY;
          end
        end
        S_MN: begin
          if (w + OW'(6) + a_dl > PG_LIMIT) begin
            state <= S_DONE;
          end else begin
            e_pg <= ~active_page; e_key <= a_key; e_len <= a_len;
            e_stg <= 1'b1; e_doff <= '0; e_ret <= S_MV; state <= S_E_KEY;
          end
        end
        S_MV: begin
          p_addr <= hwa(~active_page, OW'(0)); p_val <= ST_VALID;
          p_ret  <= S_ME; state <= S_P_RD;
        end
        S_ME: begin
          er_addr <= (AW + 1)'(hwa(active_page, OW'(0)));
          er_end  <= (AW + 1)'(hwa(active_page, OW'(0))) + (AW + 1)'(PAGE_HW);
          er_ret  <= S_MD;
          state   <= S_ER;
        end
        S_MD: begin
          active_page <= ~active_page;
          wp          <= w;
          state       <= S_OKD;
        end

        // Record emitter: key, length, data halfwords, commit word.
        S_E_KEY: begin
          p_addr <= hwa(e_pg, w); p_val <= e_key;
          p_ret  <= S_E_LEN; state <= S_P_RD;
        end
        S_E_LEN: begin
          p_addr <= hwa(e_pg, w + OW'(2)); p_val <= e_len;
          p_ret  <= S_E_DAT; state <= S_P_RD;
          e_j    <= '0;
        end
        S_E_DAT: begin
          if (16'(e_j) < e_n) begin
            state <= S_E_DV;
          end else begin
            p_addr <= hwa(e_pg, w + OW'(4) + e_dl); p_val <= COMMIT_WORD;
            p_ret  <= S_E_END; state <= S_P_RD;
          end
        end
        S_E_DV: begin
          p_addr <= hwa(e_pg, w + OW'(4) + OW'({e_j, 1'b0})); p_val <= e_v;
          p_ret  <= S_E_DAT; state <= S_P_RD;
          e_j    <= e_j + 1'b1;
        end
        S_E_END: begin
          w     <= w + OW'(6) + e_dl;
          state <= e_ret;
        end

        // Log walk: one committed record per pass.
        S_WK_A: begin
          if (w_p + OW'(4) > PG_LIMIT) begin
            state <= w_ret;
          end else begin
            state <= S_WK_B;
          end
        end
        S_WK_B: begin
          w_k   <= st_q;
          state <= S_WK_C;
        end
        S_WK_C: begin
          w_l <= st_q;
          if (w_k == ERASED_HW && st_q == ERASED_HW) begin
            state <= w_ret;
          end else if (w_k == ERASED_HW || st_q == ERASED_HW ||
                       w_p + OW'(6) + wk_dl_c > PG_LIMIT) begin
            w_torn <= 1'b1;
            state  <= w_ret;
          end else begin
            state <= S_WK_D;
          end
        end
        S_WK_D: begin
          if (st_q != COMMIT_WORD) begin
            w_torn <= 1'b1;
            state  <= w_ret;
          end else begin
            if (w_any && w_k == w_want) begin
              w_found <= 1'b1;
              w_doff  <= w_p + OW'(4);
              w_dlen  <= w_l;
            end
            w_p   <= w_p + OW'(6) + wk_dl;
            state <= S_WK_A;
          end
        end

        // Program: read the halfword, then write it ANDed with the value.
        S_P_RD: state <= S_P_WR;
        S_P_WR: state <= p_ret;

        // Erase sweep, one halfword per cycle.
        S_ER: begin
          er_addr <= er_addr + 1'b1;
          if (er_addr + 1'b1 == er_end) begin
            state <= er_ret;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The block never takes an item while a result is still offered.
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  // A result never carries a status code outside the defined set.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STAT_OK || status == STAT_FAIL || status == STAT_NOT_FOUND))
    else $error("undefined status code");

  // A copied length only comes with a successful read.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && copy_length != 10'd0 |-> status == STAT_OK)
    else $error("copy length on a failed item");

  // Read data is only returned within the copied length.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && read_data != 16'd0 |-> copy_length != 10'd0)
    else $error("read data without copied bytes");
`endif

endmodule

// ===== sim/flash_eeprom_emulation_log_tb.sv =====
// ----------------------------------------------------------------------------
// flash_eeprom_emulation_log_tb: self-checking bench for the EEPROM emulation
// Sends init, write, read and raw program transfers through a bursty sender,
// keeps its own copy of the flash store and log pointers to predict every
// result, and checks each result transfer field by field as it arrives.
// ----------------------------------------------------------------------------
module flash_eeprom_emulation_log_tb;
  import feel_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PG_BYTES = PAGE_BYTES_DEF;
  localparam int PG_HW    = PG_BYTES / 2;
  localparam int N_ITEMS  = 650;

  typedef struct packed {
    logic [1:0]  act;
    logic [15:0] key;
    logic [15:0] len;
    logic [15:0] dat;
    logic        lst;
    logic [9:0]  idx;
    logic [15:0] maxl;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  copy_len;
    logic [15:0] rdata;
    logic        page;
    logic [10:0] wptr;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = ACT_INIT;
  logic [15:0] key = '0;
  logic [15:0] length = '0;
  logic [15:0] data = '0;
  logic        last = 1'b0;
  logic [9:0]  index = '0;
  logic [15:0] max_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [9:0]  copy_length;
  logic [15:0] read_data;
  logic        active_page;
  logic [10:0] write_pointer;

  flash_eeprom_emulation_log u_top (.*);

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the flash store and the log state.
  logic [15:0] shadow_flash [2*PG_HW];
  logic        sh_page;
  int unsigned sh_wptr;
  bit          sh_inited;
  logic [15:0] sh_stage [PG_HW];
  int unsigned sh_stage_cnt;

  req_t  pending_reqs[$];
  resp_t expected_q[$];

  int unsigned n_accepted, n_checked, n_mismatch, n_moves, n_move_fail, n_appends;
  int unsigned n_hold_done;
  bit          in_acc = 1'b0;

  function automatic int unsigned hw_at(logic pg, int unsigned off);
    return (pg ? PG_HW : 0) + ((off >> 1) % PG_HW);
  endfunction

  function automatic logic [15:0] flash_rd(logic pg, int unsigned off);
    return shadow_flash[hw_at(pg, off)];
  endfunction

  function automatic void flash_prog(logic pg, int unsigned off, logic [15:0] v);
    shadow_flash[hw_at(pg, off)] &= v;
  endfunction

  function automatic void flash_erase(logic pg);
    for (int i = 0; i < PG_HW; i++) shadow_flash[(pg ? PG_HW : 0) + i] = ERASED_HW;
  endfunction

  function automatic bit seq_is_newer(logic [15:0] a, logic [15:0] b);
    logic [15:0] diff;
    diff = a - b;
    return (a != b) && (diff < SEQ_HALF);
  endfunction

  // Walks the committed records of a page; want above 16 bits matches nothing.
  function automatic int unsigned walk_log(logic pg, int unsigned want, output bit torn,
                                           output bit found, output int unsigned doff,
                                           output int unsigned dlen);
    int unsigned p, k, l, dl;
    p = HDR_BYTES;
    torn = 0;
    found = 0;
    doff = 0;
    dlen = 0;
    forever begin
      if (p + 4 > PG_BYTES) break;
      k = flash_rd(pg, p);
      l = flash_rd(pg, p + 2);
      if (k == ERASED_HW && l == ERASED_HW) break;
      if (k == ERASED_HW || l == ERASED_HW) begin
        torn = 1;
        break;
      end
      dl = (l + 1) & ~32'd1;
      if (p + 4 + dl + 2 > PG_BYTES) begin
        torn = 1;
        break;
      end
      if (flash_rd(pg, p + 4 + dl) != COMMIT_WORD) begin
        torn = 1;
        break;
      end
      if (k == want) begin
        found = 1;
        doff = p + 4;
        dlen = l;
      end
      p += 4 + dl + 2;
    end
    return p;
  endfunction

  function automatic void rescan_pointer();
    bit torn, found;
    int unsigned d, l, p;
    p = walk_log(sh_page, 32'h10000, torn, found, d, l);
    sh_wptr = torn ? PG_BYTES : p;
  endfunction

  // Writes the staged record at byte offset w of page pg.
  function automatic void append_staged(logic pg, int unsigned w, logic [15:0] k,
                                        int unsigned len);
    int unsigned n;
    logic [15:0] v;
    n = (len + 1) / 2;
    flash_prog(pg, w, k);
    flash_prog(pg, w + 2, len[15:0]);
    for (int i = 0; i < n; i++) begin
      v = sh_stage[i];
      if (i + 1 == n && len[0]) v = {8'hFF, v[7:0]};
      flash_prog(pg, w + 4 + 2 * i, v);
    end
    flash_prog(pg, w + 4 + 2 * n, COMMIT_WORD);
  endfunction

  // Moves the kept keys to the other page and adds the new record there.
  function automatic bit move_page(logic [15:0] k_new, int unsigned len);
    logic src, dst;
    int unsigned w, dl, d, l;
    bit torn, found;
    logic [15:0] kk;
    src = sh_page;
    dst = ~sh_page;
    w = HDR_BYTES;
    n_moves++;
    flash_erase(dst);
    flash_prog(dst, 0, ST_RECEIVE);
    flash_prog(dst, 2, flash_rd(src, 2) + 16'd1);
    for (int i = 0; i < NUM_KEPT_KEYS_DEF && i < KEY_TABLE_SIZE; i++) begin
      kk = KEPT_KEYS[i];
      if (kk == k_new) continue;
      void'(walk_log(src, kk, torn, found, d, l));
      if (!found) continue;
      dl = (l + 1) & ~32'd1;
      if (w + 6 + dl > PG_BYTES) return 0;
      flash_prog(dst, w, kk);
      flash_prog(dst, w + 2, l[15:0]);
      for (int j = 0; j < dl; j += 2) flash_prog(dst, w + 4 + j, flash_rd(src, d + j));
      flash_prog(dst, w + 4 + dl, COMMIT_WORD);
      w += 6 + dl;
    end
    dl = (len + 1) & ~32'd1;
    if (w + 6 + dl > PG_BYTES) return 0;
    append_staged(dst, w, k_new, len);
    flash_prog(dst, 0, ST_VALID);
    flash_erase(src);
    sh_page = dst;
    sh_wptr = w + 6 + dl;
    return 1;
  endfunction

  function automatic void init_log();
    logic [15:0] s0, q0, s1, q1;
    s0 = flash_rd(0, 0);
    q0 = flash_rd(0, 2);
    s1 = flash_rd(1, 0);
    q1 = flash_rd(1, 2);
    sh_inited = 1;
    sh_stage_cnt = 0;
    if (s0 == ST_VALID && s1 != ST_VALID) sh_page = 0;
    else if (s1 == ST_VALID && s0 != ST_VALID) sh_page = 1;
    else if (s0 == ST_VALID && s1 == ST_VALID) sh_page = seq_is_newer(q0, q1) ? 1'b0 : 1'b1;
    else if (s0 == ST_RECEIVE && s1 == ST_RECEIVE) begin
      sh_page = seq_is_newer(q0, q1) ? 1'b0 : 1'b1;
      flash_prog(sh_page, 0, ST_VALID);
    end else begin
      flash_erase(0);
      flash_prog(0, 0, ST_VALID);
      flash_prog(0, 2, 16'd1);
      sh_page = 0;
      sh_wptr = HDR_BYTES;
      return;
    end
    rescan_pointer();
  endfunction

  function automatic logic [1:0] write_halfword(req_t r);
    int unsigned len, cnt, need;
    len = r.len;
    if (sh_stage_cnt < PG_HW) begin
      sh_stage[sh_stage_cnt] = r.dat;
      sh_stage_cnt++;
    end
    if (!r.lst) return STAT_OK;
    cnt = sh_stage_cnt;
    sh_stage_cnt = 0;
    if (len > PG_BYTES - 14 || cnt < (len + 1) / 2) return STAT_FAIL;
    need = 6 + ((len + 1) & ~32'd1);
    if (PG_BYTES - sh_wptr < need) begin
      if (move_page(r.key, len)) return STAT_OK;
      n_move_fail++;
      return STAT_FAIL;
    end
    append_staged(sh_page, sh_wptr, r.key, len);
    sh_wptr += need;
    n_appends++;
    return STAT_OK;
  endfunction

  // Computes the result of one accepted request and updates the shadow state.
  function automatic resp_t log_step(req_t r);
    resp_t o;
    bit torn, found;
    int unsigned d, l, off, cp, rd;
    o.status = STAT_FAIL;
    cp = 0;
    rd = 0;
    if (r.act == ACT_INIT) begin
      init_log();
      o.status = STAT_OK;
    end else if (sh_inited) begin
      case (r.act)
        ACT_WRITE: o.status = write_halfword(r);
        ACT_READ: begin
          off = r.idx * 2;
          void'(walk_log(sh_page, r.key, torn, found, d, l));
          if (!found) o.status = STAT_NOT_FOUND;
          else begin
            o.status = STAT_OK;
            cp = (l <= r.maxl) ? l : r.maxl;
            if (off < cp) begin
              rd = flash_rd(sh_page, d + off);
              if (off + 1 >= cp) rd &= 32'hFF;
            end
          end
        end
        default: begin
          shadow_flash[r.idx % (2 * PG_HW)] &= r.dat;
          o.status = STAT_OK;
        end
      endcase
    end
    o.copy_len = cp[9:0];
    o.rdata = rd[15:0];
    o.page = sh_page;
    o.wptr = sh_wptr[10:0];
    return o;
  endfunction

  // Request and result transfers are checked and predicted on the rising edge.
  always @(posedge clk) begin
    resp_t got, exp_r;
    in_acc <= in_valid && in_ready && !rst;
    if (!rst && out_valid && out_ready) begin
      got = '{status, copy_length, read_data, active_page, write_pointer};
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("ERROR: result transfer with nothing expected");
      end else begin
        exp_r = expected_q.pop_front();
        n_checked++;
        if (got != exp_r) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("ERROR: result %0d exp st=%0d cl=%0d rd=%h pg=%0d wp=%0d got st=%0d cl=%0d rd=%h pg=%0d wp=%0d",
                     n_checked, exp_r.status, exp_r.copy_len, exp_r.rdata, exp_r.page,
                     exp_r.wptr, got.status, got.copy_len, got.rdata, got.page, got.wptr);
        end
      end
    end
    if (!rst && in_valid && in_ready) begin
      expected_q.push_back(log_step('{action, key, length, data, last, index, max_length}));
      n_accepted++;
    end
  end

  // Sender: bursts of requests with random gaps, changing on the falling edge.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    req_t r;
    if (!rst && !(in_valid && !in_acc)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        action <= r.act;
        key <= r.key;
        length <= r.len;
        data <= r.dat;
        last <= r.lst;
        index <= r.idx;
        max_length <= r.maxl;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern is re-drawn from a running counter; one long hold-off mid-run.
  int stall_mode = 0;
  int mode_cnt = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      mode_cnt <= mode_cnt + 1;
      if (mode_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
        if (hold_left == 1) n_hold_done <= n_hold_done + 1;
      end else if (n_hold_done == 0 && n_checked >= 200) begin
        out_ready <= 1'b0;
        hold_left <= 400;
      end else begin
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 0);
          2: out_ready <= ($urandom_range(0, 4) != 0);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  function automatic req_t mk_req(logic [1:0] a, logic [15:0] k, logic [15:0] len,
                                  logic [15:0] d, logic l, logic [9:0] ix,
                                  logic [15:0] ml);
    req_t r;
    r = '{a, k, len, d, l, ix, ml};
    return r;
  endfunction

  // Queues a record of nhw data halfwords; only the final one carries len.
  task automatic add_record(logic [15:0] k, logic [15:0] len, int nhw);
    for (int i = 0; i < nhw; i++)
      pending_reqs.push_back(mk_req(ACT_WRITE, k, (i == nhw - 1) ? len : $urandom_range(0, 65535),
                                    $urandom_range(0, 65535), i == nhw - 1,
                                    $urandom_range(0, 1023), $urandom_range(0, 65535)));
  endtask

  task automatic add_read(logic [15:0] k, logic [9:0] ix, logic [15:0] ml);
    pending_reqs.push_back(mk_req(ACT_READ, k, $urandom_range(0, 65535),
                                  $urandom_range(0, 65535), $urandom_range(0, 1), ix, ml));
  endtask

  task automatic add_simple(logic [1:0] a, logic [9:0] ix, logic [15:0] d);
    pending_reqs.push_back(mk_req(a, $urandom_range(0, 65535), $urandom_range(0, 65535), d,
                                  $urandom_range(0, 1), ix, $urandom_range(0, 65535)));
  endtask

  function automatic logic [15:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return KEPT_KEYS[$urandom_range(0, NUM_KEPT_KEYS_DEF - 1)];
    if (sel < 9) return 16'h0040 + $urandom_range(0, 5);
    return $urandom_range(0, 65535);
  endfunction

  function automatic int pick_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 85) return $urandom_range(0, 24);
    if (sel < 95) return $urandom_range(25, 200);
    if (sel < 99) return $urandom_range(201, PG_BYTES - 14);
    return $urandom_range(PG_BYTES - 13, 65535);
  endfunction

  // Stimulus generation and end of run.
  initial begin
    int len, sel, nhw;
    logic [15:0] k;

    // Directed part: requests before init, formatting, reads at the edges,
    // failing writes, a torn record and the page move that follows.
    add_read(16'h0010, 10'd0, 16'hFFFF);
    add_record(16'h0010, 16'd2, 1);
    add_simple(ACT_RAW, 10'd0, 16'h0000);
    add_simple(ACT_INIT, 10'd0, 16'h0000);
    pending_reqs.push_back(mk_req(ACT_WRITE, 16'h0010, 16'd0, 16'h1234, 1'b0, 10'd0, 16'd0));
    pending_reqs.push_back(mk_req(ACT_WRITE, 16'h0010, 16'd3, 16'hABCD, 1'b1, 10'd0, 16'd0));
    add_read(16'h0010, 10'd0, 16'hFFFF);
    add_read(16'h0010, 10'd1, 16'hFFFF);
    add_read(16'h0010, 10'd0, 16'd1);
    add_read(16'h0010, 10'd1, 16'd0);
    add_read(16'h0010, 10'd1023, 16'hFFFF);
    add_record(16'hFFFF, 16'd0, 1);
    add_read(16'hFFFF, 10'd0, 16'hFFFF);
    add_record(16'h0020, 16'd1011, 1);
    add_record(16'h0021, 16'hFFFF, 1);
    add_record(16'h0021, 16'd6, 2);
    add_read(16'h5555, 10'd0, 16'hFFFF);
    add_simple(ACT_RAW, 10'd12, 16'h1234);
    add_simple(ACT_INIT, 10'd0, 16'h0000);
    add_record(16'h0100, 16'd2, 1);
    add_read(16'h0010, 10'd0, 16'hFFFF);
    add_read(16'h0100, 10'd0, 16'hFFFF);

    // Random part: mostly well-formed records and reads, with header edits,
    // stray raw programs, re-inits and short records mixed in.
    while (pending_reqs.size() < N_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        k = pick_key();
        len = pick_len();
        nhw = (len + 1) / 2;
        if (nhw < 1 || nhw > 520) nhw = $urandom_range(1, 3);
        if ($urandom_range(0, 19) == 0) nhw = $urandom_range(1, nhw);
        // Near the end of the run, keep records short so the item count holds.
        if (pending_reqs.size() + nhw > N_ITEMS + 16) begin
          len = $urandom_range(0, 24);
          nhw = (len + 1) / 2;
          if (nhw < 1) nhw = 1;
        end
        add_record(k, len[15:0], nhw);
      end else if (sel < 85) begin
        add_read(pick_key(), ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                        : $urandom_range(0, 12),
                 ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 30));
      end else if (sel < 90) begin
        add_simple(ACT_INIT, $urandom_range(0, 1023), $urandom_range(0, 65535));
      end else if (sel < 95) begin
        // Rewrite a page header, then init to pick the active page again.
        add_simple(ACT_RAW, ($urandom_range(0, 1) ? PG_HW : 0),
                   ($urandom_range(0, 1) ? ST_VALID : ST_RECEIVE));
        add_simple(ACT_RAW, ($urandom_range(0, 1) ? PG_HW : 0) + 1, $urandom_range(0, 65535));
        add_simple(ACT_INIT, 10'd0, 16'h0000);
      end else begin
        add_simple(ACT_RAW, $urandom_range(0, 1023), $urandom_range(0, 65535));
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_q.size() == 0);
    repeat (3000) @(posedge clk);

    $display("Run covered %0d request transfers and %0d checked results.", n_accepted,
             n_checked);
    $display("Appends %0d, page moves %0d (%0d overflowed), mismatches %0d.", n_appends,
             n_moves, n_move_fail, n_mismatch);
    if (n_mismatch == 0 && expected_q.size() == 0) begin
      $display("flash_eeprom_emulation_log test passed");
    end else begin
      $display("flash_eeprom_emulation_log test failed");
    end
    $finish;
  end

  // Ends a hung run.
  initial begin
    #500_000_000;
    $display("flash_eeprom_emulation_log test failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < 2 * PG_HW; i++) shadow_flash[i] = ERASED_HW;
    for (int i = 0; i < PG_HW; i++) sh_stage[i] = '0;
    sh_page = 0;
    sh_wptr = 0;
    sh_inited = 0;
    sh_stage_cnt = 0;
    n_accepted = 0;
    n_checked = 0;
    n_mismatch = 0;
    n_moves = 0;
    n_move_fail = 0;
    n_appends = 0;
    n_hold_done = 0;
  end

endmodule
